[rtl/bdd_pkg.sv]
// ----------------------------------------------------------------------------
// bdd_pkg
// Shared types, address map constants and decode functions for the bus
// decoder with its halfword copy channel.
// ----------------------------------------------------------------------------
`default_nettype none

package bdd_pkg;

	// Address map
	localparam logic [31:0] A_DISPLAY   = 32'h0400_0000;
	localparam logic [31:0] A_LINECNT   = 32'h0400_0006;
	localparam logic [31:0] A_SRC_REG   = 32'h0400_00d4;
	localparam logic [31:0] A_DST_REG   = 32'h0400_00d8;
	localparam logic [31:0] A_CNT_REG   = 32'h0400_00dc;
	localparam logic [31:0] A_KEYS      = 32'h0400_0130;
	localparam logic [31:0] A_IRQ_EN    = 32'h0400_0208;
	localparam logic [31:0] HIGH_NIBBLE = 32'hF000_0000;
	localparam logic [31:0] VIDEO_FIRST = 32'h0600_0000;
	localparam logic [31:0] VIDEO_LAST  = 32'h0601_7FFF;
	localparam logic [31:0] VIDEO_END   = 32'h06FF_FFFF;
	localparam logic [31:0] WRAM_FIRST  = 32'h0200_0000;
	localparam logic [31:0] WRAM_LAST   = 32'h0203_FFFF;
	localparam logic [31:0] IRAM_FIRST  = 32'h0300_0000;
	localparam logic [31:0] IRAM_LAST   = 32'h0300_7FFF;
	localparam logic [31:0] ROM_FIRST   = 32'h0800_0000;
	localparam logic [31:0] ROM_LAST    = 32'h09FF_FFFF;

	// Count/control register fields (upper halfword)
	localparam logic [15:0] TYPE_MASK  = 16'h7E1F;
	localparam logic [15:0] ENABLE_BIT = 16'h8000;

	// Queue between front and back
	localparam int Q_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2,
		OP_RSVD  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		SIZE_BYTE = 2'd0,
		SIZE_HALF = 2'd1,
		SIZE_WORD = 2'd2,
		SIZE_RSVD = 2'd3
	} size_t_t;

	typedef enum logic [3:0] {
		ROUTE_MAIN    = 4'd0,
		ROUTE_KEYS    = 4'd1,
		ROUTE_LINECNT = 4'd2,
		ROUTE_DISPLAY = 4'd3,
		ROUTE_VIDEO   = 4'd4,
		ROUTE_DMA_REG = 4'd5,
		ROUTE_IRQ_EN  = 4'd6,
		ROUTE_DROPPED = 4'd7,
		ROUTE_NONE    = 4'd8
	} route_t;

	typedef enum logic [3:0] {
		ERR_OK          = 4'd0,
		ERR_BAD_ADDR    = 4'd1,
		ERR_BAD_DST_CTL = 4'd2,
		ERR_BAD_SRC_CTL = 4'd3,
		ERR_BAD_TYPE    = 4'd4,
		ERR_NO_ENABLE   = 4'd5,
		ERR_ZERO_COUNT  = 4'd6,
		ERR_UNUSED_VID  = 4'd7,
		ERR_BUSY        = 4'd8
	} err_t;

	typedef enum logic [1:0] {
		SRC_MAIN    = 2'd0,
		SRC_LINECNT = 2'd1,
		SRC_INVALID = 2'd2
	} src_route_t;

	typedef enum logic [1:0] {
		STEP_INC  = 2'd0,
		STEP_DEC  = 2'd1,
		STEP_HOLD = 2'd2,
		STEP_RSVD = 2'd3
	} step_t;

	// Class of a word as seen by the back part
	typedef enum logic [2:0] {
		KIND_NOP    = 3'd0,
		KIND_TICK   = 3'd1,
		KIND_ACCESS = 3'd2,
		KIND_SRC_WR = 3'd3,
		KIND_DST_WR = 3'd4,
		KIND_CNT_WR = 3'd5
	} kind_t;

	// Classified word passed from front to back
	typedef struct packed {
		kind_t       kind;
		route_t      route;
		err_t        err;
		logic [31:0] addr;
		logic [31:0] data;
	} entry_t;

	typedef struct packed {
		route_t route;
		err_t   err;
	} decode_t;

	function automatic logic in_range(input logic [31:0] a, input logic [31:0] lo,
			input logic [31:0] hi);
		return (a >= lo) && (a <= hi);
	endfunction

	function automatic logic mem_ok(input logic [31:0] a);
		return ((a & HIGH_NIBBLE) != 32'd0) || in_range(a, WRAM_FIRST, WRAM_LAST) ||
			in_range(a, IRAM_FIRST, IRAM_LAST) || in_range(a, ROM_FIRST, ROM_LAST);
	endfunction

	// Halfword write decode
	function automatic decode_t decode_w16(input logic [31:0] a, input logic in_copy);
		decode_t d;
		d.route = ROUTE_NONE;
		d.err   = ERR_OK;
		if (a == A_DISPLAY) begin
			d.route = ROUTE_DISPLAY;
		end else if (in_range(a, VIDEO_FIRST, VIDEO_END)) begin
			if (a <= VIDEO_LAST) begin
				d.route = ROUTE_VIDEO;
			end else if (in_copy) begin
				d.route = ROUTE_DROPPED;
			end else begin
				d.err = ERR_UNUSED_VID;
			end
		end else if (mem_ok(a)) begin
			d.route = ROUTE_MAIN;
		end else begin
			d.err = ERR_BAD_ADDR;
		end
		return d;
	endfunction

	function automatic logic [31:0] step_delta(input step_t code);
		logic [31:0] d;
		unique case (code)
			STEP_DEC:  d = 32'hFFFF_FFFE;
			STEP_HOLD: d = 32'd0;
			default:   d = 32'd2;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

[rtl/bdd_front.sv]
// ----------------------------------------------------------------------------
// bdd_front
// Accepts bus words and classifies them: opcode, size and address are
// decoded into a word class with the route and error it gets when no copy
// is running.
// ----------------------------------------------------------------------------
`default_nettype none

module bdd_front import bdd_pkg::*; (
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [1:0]  access_size,
	input  wire logic [31:0] access_address,
	input  wire logic [31:0] write_data,
	input  wire logic        q_full,
	output logic             push,
	output entry_t           entry
);

	logic [15:0] cnt_hi;
	logic [1:0]  dst_ctl;
	logic [1:0]  src_ctl;
	decode_t     w16;

	assign req_stall = q_full;
	assign push      = req_valid && !q_full;

	assign cnt_hi  = write_data[31:16];
	assign dst_ctl = cnt_hi[6:5];
	assign src_ctl = cnt_hi[8:7];
	assign w16     = decode_w16(access_address, 1'b0);

	// Classify the word
	always_comb begin
		entry.kind  = KIND_NOP;
		entry.route = ROUTE_NONE;
		entry.err   = ERR_OK;
		entry.addr  = access_address;
		entry.data  = write_data;
		if (opcode == OP_TICK) begin
			entry.kind = KIND_TICK;
		end else if ((opcode == OP_READ || opcode == OP_WRITE) && access_size != SIZE_RSVD) begin
			entry.kind = KIND_ACCESS;
			if (access_size == SIZE_BYTE) begin
				if (mem_ok(access_address)) entry.route = ROUTE_MAIN;
				else entry.err = ERR_BAD_ADDR;
			end else if (opcode == OP_READ) begin
				priority if (access_size == SIZE_WORD && access_address == A_KEYS) begin
					entry.route = ROUTE_KEYS;
				end else if (access_size == SIZE_HALF && access_address == A_LINECNT) begin
					entry.route = ROUTE_LINECNT;
				end else if (mem_ok(access_address)) begin
					entry.route = ROUTE_MAIN;
				end else begin
					entry.err = ERR_BAD_ADDR;
				end
			end else if (access_size == SIZE_HALF) begin
				entry.route = w16.route;
				entry.err   = w16.err;
			end else begin
				priority if (access_address == A_IRQ_EN) begin
					entry.route = ROUTE_IRQ_EN;
				end else if (access_address == A_SRC_REG) begin
					entry.kind  = KIND_SRC_WR;
					entry.route = ROUTE_DMA_REG;
				end else if (access_address == A_DST_REG) begin
					entry.kind  = KIND_DST_WR;
					entry.route = ROUTE_DMA_REG;
				end else if (access_address == A_CNT_REG) begin
					entry.kind  = KIND_CNT_WR;
					entry.route = ROUTE_DMA_REG;
					priority if (dst_ctl == STEP_RSVD) entry.err = ERR_BAD_DST_CTL;
					else if (src_ctl == STEP_RSVD) entry.err = ERR_BAD_SRC_CTL;
					else if ((cnt_hi & TYPE_MASK) != 16'd0) entry.err = ERR_BAD_TYPE;
					else if ((cnt_hi & ENABLE_BIT) == 16'd0) entry.err = ERR_NO_ENABLE;
					else if (write_data[15:0] == 16'd0) entry.err = ERR_ZERO_COUNT;
					else entry.err = ERR_OK;
				end else if (mem_ok(access_address)) begin
					entry.route = ROUTE_MAIN;
				end else begin
					entry.err = ERR_BAD_ADDR;
				end
			end
		end
	end

endmodule

`default_nettype wire

[rtl/bdd_queue.sv]
// ----------------------------------------------------------------------------
// bdd_queue
// Short first-in first-out queue of classified words between the front and
// the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module bdd_queue import bdd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t push_entry,
	output logic        full,
	input  wire logic   pop,
	output logic        head_valid,
	output entry_t      head_entry
);

	localparam int PtrW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CntW = $clog2(Q_DEPTH + 1);

	entry_t            slots_q [Q_DEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign full       = (count_q == CntW'(Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = slots_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Store the word at the tail
	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_entry;
	end

endmodule

`default_nettype wire

[rtl/bdd_back.sv]
// ----------------------------------------------------------------------------
// bdd_back
// Carries out classified words against the copy channel state: register
// writes, copy start, one transfer per tick, busy rejection. Holds the
// result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdd_back import bdd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   head_valid,
	input  wire entry_t head_entry,
	output logic        pop,
	output logic        rsp_valid,
	input  wire logic   rsp_stall,
	output logic [3:0]  route,
	output logic [3:0]  error_code,
	output logic [31:0] target_address,
	output logic [31:0] source_address,
	output logic [1:0]  source_route,
	output logic        is_transfer,
	output logic        last_transfer
);

	// Copy channel state
	logic [31:0] copy_src_q;
	logic [31:0] copy_dst_q;
	step_t       src_step_q;
	step_t       dst_step_q;
	logic [15:0] remain_q;
	logic        busy_q;

	logic [31:0] copy_src_d;
	logic [31:0] copy_dst_d;
	step_t       src_step_d;
	step_t       dst_step_d;
	logic [15:0] remain_d;
	logic        busy_d;

	// Result of the word at the head
	route_t      res_route;
	err_t        res_err;
	logic [31:0] res_target;
	logic [31:0] res_src;
	src_route_t  res_sroute;
	logic        res_xfer;
	logic        res_last;

	logic        out_valid_q;
	decode_t     dst_dec;
	src_route_t  tick_sroute;

	assign pop       = head_valid && (!out_valid_q || !rsp_stall);
	assign rsp_valid = out_valid_q;
	assign dst_dec   = decode_w16(copy_dst_q, 1'b1);

	// Classify the transfer source
	always_comb begin
		priority if (copy_src_q == A_LINECNT) tick_sroute = SRC_LINECNT;
		else if (mem_ok(copy_src_q)) tick_sroute = SRC_MAIN;
		else tick_sroute = SRC_INVALID;
	end

	// Execute the head word
	always_comb begin
		copy_src_d = copy_src_q;
		copy_dst_d = copy_dst_q;
		src_step_d = src_step_q;
		dst_step_d = dst_step_q;
		remain_d   = remain_q;
		busy_d     = busy_q;
		res_route  = head_entry.route;
		res_err    = head_entry.err;
		res_target = head_entry.addr;
		res_src    = 32'd0;
		res_sroute = SRC_MAIN;
		res_xfer   = 1'b0;
		res_last   = 1'b0;
		unique case (head_entry.kind)
			KIND_TICK: begin
				if (busy_q) begin
					res_xfer   = 1'b1;
					res_target = copy_dst_q;
					res_src    = copy_src_q;
					res_sroute = tick_sroute;
					res_route  = dst_dec.route;
					res_err    = (dst_dec.err != ERR_OK || tick_sroute == SRC_INVALID) ?
						ERR_BAD_ADDR : ERR_OK;
					res_last   = (remain_q == 16'd1);
					copy_src_d = copy_src_q + step_delta(src_step_q);
					copy_dst_d = copy_dst_q + step_delta(dst_step_q);
					remain_d   = remain_q - 16'd1;
					busy_d     = (remain_q != 16'd1);
				end
			end
			KIND_ACCESS, KIND_SRC_WR, KIND_DST_WR, KIND_CNT_WR: begin
				if (busy_q) begin
					res_route = ROUTE_NONE;
					res_err   = ERR_BUSY;
				end else if (head_entry.kind == KIND_SRC_WR) begin
					copy_src_d = head_entry.data;
				end else if (head_entry.kind == KIND_DST_WR) begin
					copy_dst_d = head_entry.data;
				end else if (head_entry.kind == KIND_CNT_WR && head_entry.err == ERR_OK) begin
					dst_step_d = step_t'(head_entry.data[22:21]);
					src_step_d = step_t'(head_entry.data[24:23]);
					remain_d   = head_entry.data[15:0];
					busy_d     = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Update channel state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_src_q  <= '0;
			copy_dst_q  <= '0;
			src_step_q  <= STEP_INC;
			dst_step_q  <= STEP_INC;
			remain_q    <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				copy_src_q <= copy_src_d;
				copy_dst_q <= copy_dst_d;
				src_step_q <= src_step_d;
				dst_step_q <= dst_step_d;
				remain_q   <= remain_d;
				busy_q     <= busy_d;
			end
			if (pop) out_valid_q <= 1'b1;
			else if (!rsp_stall) out_valid_q <= 1'b0;
		end
	end

	// Load the result word
	always_ff @(posedge clk) begin
		if (pop) begin
			route          <= res_route;
			error_code     <= res_err;
			target_address <= res_target;
			source_address <= res_src;
			source_route   <= res_sroute;
			is_transfer    <= res_xfer;
			last_transfer  <= res_last;
		end
	end

endmodule

`default_nettype wire

[rtl/bus_decoder_with_dma_channel_top.sv]
// ----------------------------------------------------------------------------
// bus_decoder_with_dma_channel_top
// Bus decoder with one halfword copy channel.
// ----------------------------------------------------------------------------
// Every accepted word (read, write or tick) yields exactly one result word,
// in order. The block takes one word per clock while the queue is not
// full. Each word is held first in the two-entry queue behind the decode
// front, then in the output register of the execute back end, where the
// copy channel state is updated and read once per word. A stalled result
// side fills the queue; the request side is stalled only when the queue is
// full. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bus_decoder_with_dma_channel_top import bdd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [1:0]  access_size,
	input  wire logic [31:0] access_address,
	input  wire logic [31:0] write_data,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic [3:0]       route,
	output logic [3:0]       error_code,
	output logic [31:0]      target_address,
	output logic [31:0]      source_address,
	output logic [1:0]       source_route,
	output logic             is_transfer,
	output logic             last_transfer
);

	logic   q_full;
	logic   push;
	entry_t push_entry;
	logic   pop;
	logic   head_valid;
	entry_t head_entry;

	// Decode incoming words
	bdd_front u_front (
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.opcode         (opcode),
		.access_size    (access_size),
		.access_address (access_address),
		.write_data     (write_data),
		.q_full         (q_full),
		.push           (push),
		.entry          (push_entry)
	);

	// Buffer classified words
	bdd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	// Execute against the copy channel
	bdd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_entry     (head_entry),
		.pop            (pop),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.route          (route),
		.error_code     (error_code),
		.target_address (target_address),
		.source_address (source_address),
		.source_route   (source_route),
		.is_transfer    (is_transfer),
		.last_transfer  (last_transfer)
	);

endmodule

`default_nettype wire

[test/bdd_result_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdd_result_check
// Watches both channels of the bus decoder, predicts each result word from
// its own copy of the copy channel state and compares the words in order.
// ----------------------------------------------------------------------------
// Every accepted request word queues one predicted result. Every accepted
// result word is checked field by field against the oldest prediction.
// The failure count and the number of results still due go back to the top.
// ----------------------------------------------------------------------------

module bdd_result_check import bdd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic [1:0]  opcode,
	input  logic [1:0]  access_size,
	input  logic [31:0] access_address,
	input  logic [31:0] write_data,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic [3:0]  route,
	input  logic [3:0]  error_code,
	input  logic [31:0] target_address,
	input  logic [31:0] source_address,
	input  logic [1:0]  source_route,
	input  logic        is_transfer,
	input  logic        last_transfer,
	output int          mismatch_count,
	output int          results_due
);

	typedef struct {
		route_t      route;
		err_t        err;
		logic [31:0] target;
		logic [31:0] source;
		src_route_t  sroute;
		logic        xfer;
		logic        last;
	} bus_result_t;

	// Copy channel as the predictor sees it
	logic [31:0] chan_src;
	logic [31:0] chan_dst;
	step_t       src_step;
	step_t       dst_step;
	logic [15:0] words_left;
	logic        chan_busy;

	bus_result_t due_results[$];
	bus_result_t want;
	int          result_index;

	function automatic logic main_mem(input logic [31:0] a);
		if (a[31:28] != 4'h0) begin
			return 1'b1;
		end
		return (a >= WRAM_FIRST && a <= WRAM_LAST) || (a >= IRAM_FIRST && a <= IRAM_LAST) ||
			(a >= ROM_FIRST && a <= ROM_LAST);
	endfunction

	// Halfword write target; an unused video write is dropped inside a copy run
	function automatic void half_write(input logic [31:0] a, input logic copying,
			output route_t r, output err_t e);
		r = ROUTE_NONE;
		e = ERR_OK;
		if (a == A_DISPLAY) begin
			r = ROUTE_DISPLAY;
		end else if (a >= VIDEO_FIRST && a <= VIDEO_END) begin
			if (a <= VIDEO_LAST) begin
				r = ROUTE_VIDEO;
			end else if (copying) begin
				r = ROUTE_DROPPED;
			end else begin
				e = ERR_UNUSED_VID;
			end
		end else if (main_mem(a)) begin
			r = ROUTE_MAIN;
		end else begin
			e = ERR_BAD_ADDR;
		end
	endfunction

	function automatic logic [31:0] step_amount(input step_t s);
		case (s)
			STEP_DEC:  return 32'hFFFF_FFFE;
			STEP_HOLD: return 32'd0;
			default:   return 32'd2;
		endcase
	endfunction

	// Work out the result of one request word and advance the channel state
	function automatic bus_result_t predict_word(input opcode_t op, input size_t_t sz,
			input logic [31:0] addr, input logic [31:0] data);
		bus_result_t res;
		route_t      r;
		err_t        e;
		logic [15:0] ctl;
		res.route  = ROUTE_NONE;
		res.err    = ERR_OK;
		res.target = addr;
		res.source = 32'd0;
		res.sroute = SRC_MAIN;
		res.xfer   = 1'b0;
		res.last   = 1'b0;
		ctl = data[31:16];
		if (op == OP_TICK) begin
			if (chan_busy) begin
				res.xfer   = 1'b1;
				res.target = chan_dst;
				res.source = chan_src;
				if (chan_src == A_LINECNT) begin
					res.sroute = SRC_LINECNT;
				end else if (!main_mem(chan_src)) begin
					res.sroute = SRC_INVALID;
				end
				half_write(chan_dst, 1'b1, r, e);
				res.route = r;
				res.err = (e != ERR_OK || res.sroute == SRC_INVALID) ? ERR_BAD_ADDR : ERR_OK;
				res.last = (words_left == 16'd1);
				chan_src += step_amount(src_step);
				chan_dst += step_amount(dst_step);
				words_left -= 16'd1;
				if (words_left == 16'd0) begin
					chan_busy = 1'b0;
				end
			end
		end else if (op != OP_RSVD && sz != SIZE_RSVD) begin
			if (chan_busy) begin
				res.err = ERR_BUSY;
			end else if (sz == SIZE_BYTE) begin
				if (main_mem(addr)) begin
					res.route = ROUTE_MAIN;
				end else begin
					res.err = ERR_BAD_ADDR;
				end
			end else if (op == OP_READ) begin
				if (sz == SIZE_WORD && addr == A_KEYS) begin
					res.route = ROUTE_KEYS;
				end else if (sz == SIZE_HALF && addr == A_LINECNT) begin
					res.route = ROUTE_LINECNT;
				end else if (main_mem(addr)) begin
					res.route = ROUTE_MAIN;
				end else begin
					res.err = ERR_BAD_ADDR;
				end
			end else if (sz == SIZE_HALF) begin
				half_write(addr, 1'b0, r, e);
				res.route = r;
				res.err   = e;
			end else if (addr == A_IRQ_EN) begin
				res.route = ROUTE_IRQ_EN;
			end else if (addr == A_SRC_REG) begin
				res.route = ROUTE_DMA_REG;
				chan_src = data;
			end else if (addr == A_DST_REG) begin
				res.route = ROUTE_DMA_REG;
				chan_dst = data;
			end else if (addr == A_CNT_REG) begin
				// Checks run in a fixed order; the first failure wins
				res.route = ROUTE_DMA_REG;
				if (ctl[6:5] == 2'd3) begin
					res.err = ERR_BAD_DST_CTL;
				end else if (ctl[8:7] == 2'd3) begin
					res.err = ERR_BAD_SRC_CTL;
				end else if ((ctl & TYPE_MASK) != 16'd0) begin
					res.err = ERR_BAD_TYPE;
				end else if ((ctl & ENABLE_BIT) == 16'd0) begin
					res.err = ERR_NO_ENABLE;
				end else if (data[15:0] == 16'd0) begin
					res.err = ERR_ZERO_COUNT;
				end else begin
					dst_step   = step_t'(ctl[6:5]);
					src_step   = step_t'(ctl[8:7]);
					words_left = data[15:0];
					chan_busy  = 1'b1;
				end
			end else if (main_mem(addr)) begin
				res.route = ROUTE_MAIN;
			end else begin
				res.err = ERR_BAD_ADDR;
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		$display("%0t ns: result %0d, %s: got %h, want %h", $time, result_index, what,
			got, exp_val);
		mismatch_count++;
	endtask

	// Check result words, then queue the prediction for a new request word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_results.delete();
			chan_src       = 32'd0;
			chan_dst       = 32'd0;
			src_step       = STEP_INC;
			dst_step       = STEP_INC;
			words_left     = 16'd0;
			chan_busy      = 1'b0;
			result_index   = 0;
			mismatch_count = 0;
			results_due   <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (due_results.size() == 0) begin
					report_mismatch("result with none due", {28'd0, route}, 32'd0);
				end else begin
					want = due_results.pop_front();
					if (route !== want.route)
						report_mismatch("route", 32'(route), 32'(want.route));
					if (error_code !== want.err)
						report_mismatch("error_code", 32'(error_code), 32'(want.err));
					if (target_address !== want.target)
						report_mismatch("target_address", target_address, want.target);
					if (source_address !== want.source)
						report_mismatch("source_address", source_address, want.source);
					if (source_route !== want.sroute)
						report_mismatch("source_route", 32'(source_route), 32'(want.sroute));
					if (is_transfer !== want.xfer)
						report_mismatch("is_transfer", 32'(is_transfer), 32'(want.xfer));
					if (last_transfer !== want.last)
						report_mismatch("last_transfer", 32'(last_transfer), 32'(want.last));
				end
				result_index++;
			end
			if (req_valid && !req_stall) begin
				due_results.push_back(predict_word(opcode_t'(opcode), size_t_t'(access_size),
					access_address, write_data));
			end
			results_due <= due_results.size();
		end
	end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the bus decoder with its halfword copy channel.
// ----------------------------------------------------------------------------
// A directed pass covers each route, each error and the copy run corner
// cases; then random traffic, mostly copy setups with ticks mixed with
// busy accesses, plus noise around region edges and register addresses.
// Both channels idle at random except for one quiet stretch. Checking is
// done by bdd_result_check.
// ----------------------------------------------------------------------------

module tb_top;
	import bdd_pkg::*;

	localparam int STALL_LIMIT  = 1000;
	localparam int RANDOM_WORDS = 1600;

	logic        clk;
	logic        arst_n         = 1'b0;
	logic        req_valid      = 1'b0;
	logic        req_stall;
	logic [1:0]  opcode         = 2'd0;
	logic [1:0]  access_size    = 2'd0;
	logic [31:0] access_address = 32'd0;
	logic [31:0] write_data     = 32'd0;
	logic        rsp_valid;
	logic        rsp_stall      = 1'b0;
	logic [3:0]  route;
	logic [3:0]  error_code;
	logic [31:0] target_address;
	logic [31:0] source_address;
	logic [1:0]  source_route;
	logic        is_transfer;
	logic        last_transfer;

	int   mismatch_count;
	int   results_due;
	int   stuck_cycles = 0;
	int   run_left     = 0;
	int   useful_words = 0;
	int   next_drain   = 400;
	logic quiet        = 1'b0;

	bus_decoder_with_dma_channel_top uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.opcode         (opcode),
		.access_size    (access_size),
		.access_address (access_address),
		.write_data     (write_data),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.route          (route),
		.error_code     (error_code),
		.target_address (target_address),
		.source_address (source_address),
		.source_route   (source_route),
		.is_transfer    (is_transfer),
		.last_transfer  (last_transfer)
	);

	bdd_result_check u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.opcode         (opcode),
		.access_size    (access_size),
		.access_address (access_address),
		.write_data     (write_data),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.route          (route),
		.error_code     (error_code),
		.target_address (target_address),
		.source_address (source_address),
		.source_route   (source_route),
		.is_transfer    (is_transfer),
		.last_transfer  (last_transfer),
		.mismatch_count (mismatch_count),
		.results_due    (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the result side at random, except in the quiet stretch
	always @(posedge clk) begin
		rsp_stall <= !quiet && ($urandom_range(99) < 24);
	end

	// Count cycles in which neither channel moves a word
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		wait (stuck_cycles >= STALL_LIMIT);
		$display("[bus_decoder_with_dma_channel_top] ERROR");
		$finish;
	end

	// Region edges, their neighbors, register addresses, or anything at all
	function automatic logic [31:0] pick_address();
		logic [31:0] base;
		int          r;
		r = $urandom_range(99);
		if (r < 30) begin
			return $urandom;
		end
		case ($urandom_range(19))
			0:       base = WRAM_FIRST;
			1:       base = WRAM_LAST;
			2:       base = IRAM_FIRST;
			3:       base = IRAM_LAST;
			4:       base = ROM_FIRST;
			5:       base = ROM_LAST;
			6:       base = VIDEO_FIRST;
			7:       base = VIDEO_LAST;
			8:       base = VIDEO_END;
			9:       base = 32'h1000_0000;
			10:      base = 32'h0000_0000;
			11:      base = 32'hFFFF_FFFF;
			12:      base = A_DISPLAY;
			13:      base = A_SRC_REG;
			14:      base = A_DST_REG;
			15:      base = A_CNT_REG;
			16:      base = A_KEYS;
			17:      base = A_IRQ_EN;
			default: base = A_LINECNT;
		endcase
		if (r < 65) begin
			base += $urandom_range(4) - 2;
		end
		return base;
	endfunction

	function automatic logic [31:0] control_word(input step_t dst_mode, input step_t src_mode,
			input logic enable, input logic [15:0] type_bits, input logic [15:0] count);
		logic [15:0] hi;
		hi = (type_bits & TYPE_MASK) | (enable ? ENABLE_BIT : 16'h0000);
		hi[6:5] = dst_mode;
		hi[8:7] = src_mode;
		return {hi, count};
	endfunction

	// Offer one word, hold it until taken, then maybe idle a while
	task automatic send_word(input opcode_t op, input size_t_t sz, input logic [31:0] a,
			input logic [31:0] d);
		if (op == OP_TICK) begin
			if (run_left > 0) begin
				run_left--;
				useful_words++;
			end
		end else if (op != OP_RSVD && sz != SIZE_RSVD) begin
			useful_words++;
		end
		req_valid      <= 1'b1;
		opcode         <= op;
		access_size    <= sz;
		access_address <= a;
		write_data     <= d;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		if (!quiet) begin
			while ($urandom_range(99) < 24) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	// Hold the sender until every result has come back
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
	endtask

	task automatic noise_word();
		opcode_t     op;
		size_t_t     sz;
		logic [31:0] a;
		logic [31:0] d;
		op = ($urandom_range(99) < 4) ? OP_RSVD : opcode_t'($urandom_range(2));
		sz = ($urandom_range(99) < 4) ? SIZE_RSVD : size_t_t'($urandom_range(2));
		a = pick_address();
		d = $urandom;
		// Keep stray control writes from starting a long copy run
		if (op == OP_WRITE && sz == SIZE_WORD && a == A_CNT_REG) begin
			d[31] = 1'b0;
		end
		send_word(op, sz, a, d);
	endtask

	// Set up source and destination, start a run, and tick it to the end
	task automatic copy_sequence();
		step_t       dst_mode;
		step_t       src_mode;
		logic [15:0] count;
		logic [31:0] ctl;
		dst_mode = step_t'($urandom_range(2));
		src_mode = step_t'($urandom_range(2));
		count = ($urandom_range(19) == 0) ? 16'($urandom_range(40, 8)) :
			16'($urandom_range(6, 1));
		if ($urandom_range(9) != 0) begin
			send_word(OP_WRITE, SIZE_WORD, A_SRC_REG, pick_address());
		end
		if ($urandom_range(9) != 0) begin
			send_word(OP_WRITE, SIZE_WORD, A_DST_REG, pick_address());
		end
		if ($urandom_range(99) < 15) begin
			case ($urandom_range(4))
				0:       ctl = control_word(STEP_RSVD, src_mode, 1'($urandom_range(1)),
						16'($urandom), 16'($urandom));
				1:       ctl = control_word(dst_mode, STEP_RSVD, 1'($urandom_range(1)),
						16'($urandom), 16'($urandom));
				2:       ctl = control_word(dst_mode, src_mode, 1'($urandom_range(1)),
						16'($urandom | 32'h4000), 16'($urandom));
				3:       ctl = control_word(dst_mode, src_mode, 1'b0, 16'h0000, 16'($urandom));
				default: ctl = control_word(dst_mode, src_mode, 1'b1, 16'h0000, 16'h0000);
			endcase
			send_word(OP_WRITE, SIZE_WORD, A_CNT_REG, ctl);
		end else begin
			send_word(OP_WRITE, SIZE_WORD, A_CNT_REG,
				control_word(dst_mode, src_mode, 1'b1, 16'h0000, count));
			run_left = int'(count);
		end
		while (run_left > 0) begin
			if ($urandom_range(99) < 75) begin
				send_word(OP_TICK, size_t_t'($urandom_range(3)), $urandom, $urandom);
			end else begin
				noise_word();
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Plain routes and address errors
		send_word(OP_READ, SIZE_BYTE, WRAM_FIRST, 32'h0);
		send_word(OP_READ, SIZE_BYTE, 32'h0000_0000, 32'hFFFF_FFFF);
		send_word(OP_READ, SIZE_HALF, A_LINECNT, 32'h0);
		send_word(OP_READ, SIZE_WORD, A_KEYS, 32'h0);
		send_word(OP_READ, SIZE_WORD, 32'hFFFF_FFFF, 32'h0);
		send_word(OP_READ, SIZE_HALF, ROM_LAST + 32'd1, 32'h0);
		send_word(OP_WRITE, SIZE_HALF, A_DISPLAY, 32'hFFFF_FFFF);
		send_word(OP_WRITE, SIZE_HALF, VIDEO_LAST, 32'h0);
		send_word(OP_WRITE, SIZE_HALF, VIDEO_LAST + 32'd1, 32'h0);
		send_word(OP_WRITE, SIZE_WORD, A_IRQ_EN, 32'hFFFF_FFFF);
		send_word(OP_RSVD, SIZE_WORD, A_CNT_REG, 32'hFFFF_FFFF);
		send_word(OP_WRITE, SIZE_RSVD, A_CNT_REG, 32'hFFFF_FFFF);
		send_word(OP_TICK, SIZE_HALF, 32'h0, 32'h0);

		// Each failing control check in turn
		send_word(OP_WRITE, SIZE_WORD, A_CNT_REG,
			control_word(STEP_RSVD, STEP_INC, 1'b1, 16'd0, 16'd1));
		send_word(OP_WRITE, SIZE_WORD, A_CNT_REG,
			control_word(STEP_INC, STEP_RSVD, 1'b1, 16'd0, 16'd1));
		send_word(OP_WRITE, SIZE_WORD, A_CNT_REG,
			control_word(STEP_INC, STEP_INC, 1'b1, 16'h0010, 16'd1));
		send_word(OP_WRITE, SIZE_WORD, A_CNT_REG,
			control_word(STEP_INC, STEP_INC, 1'b0, 16'd0, 16'd5));
		send_word(OP_WRITE, SIZE_WORD, A_CNT_REG,
			control_word(STEP_INC, STEP_INC, 1'b1, 16'd0, 16'd0));

		// Line counter source, destination walking off the end of video memory
		send_word(OP_WRITE, SIZE_WORD, A_SRC_REG, A_LINECNT);
		send_word(OP_WRITE, SIZE_WORD, A_DST_REG, VIDEO_LAST - 32'd1);
		send_word(OP_WRITE, SIZE_WORD, A_CNT_REG,
			control_word(STEP_INC, STEP_HOLD, 1'b1, 16'd0, 16'd3));
		run_left = 3;
		send_word(OP_READ, SIZE_WORD, A_KEYS, 32'h0);
		repeat (3) send_word(OP_TICK, SIZE_WORD, 32'h0, 32'h0);

		// Invalid source and destination on a single-step run
		send_word(OP_WRITE, SIZE_WORD, A_SRC_REG, 32'h0);
		send_word(OP_WRITE, SIZE_WORD, A_DST_REG, 32'h0);
		send_word(OP_WRITE, SIZE_WORD, A_CNT_REG,
			control_word(STEP_DEC, STEP_DEC, 1'b1, 16'd0, 16'd1));
		run_left = 1;
		send_word(OP_TICK, SIZE_BYTE, 32'h0, 32'h0);
		drain();

		// Random traffic with a quiet stretch and periodic drains
		useful_words = 0;
		while (useful_words < RANDOM_WORDS) begin
			quiet <= (useful_words >= 600 && useful_words < 850);
			if (useful_words >= next_drain) begin
				drain();
				next_drain += 400;
			end
			if ($urandom_range(99) < 55) begin
				copy_sequence();
			end else begin
				noise_word();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && results_due == 0) begin
			$display("[bus_decoder_with_dma_channel_top] OK");
		end else begin
			$display("[bus_decoder_with_dma_channel_top] ERROR");
		end
		$finish;
	end

endmodule
